// ===== src/ghue_pkg.sv =====
// Shared types and constants for the golden-ratio hue HSV to RGB core.
package ghue_pkg;

    localparam int CFG_W = 16;
    localparam int OUT_W = 16;
    localparam int ID_W  = 32;
    localparam int IDX_W = 1;

    // Register indexes on the write port
    localparam logic [IDX_W-1:0] REG_SATURATION = 1'b0;
    localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 16'h8000;

    // Golden-ratio conjugate and 0.13 offset as 0.32 fractions
    localparam logic [ID_W-1:0] PHI_FRAC    = 32'h9E37_79B9;
    localparam logic [ID_W-1:0] OFFSET_FRAC = 32'h2147_AE14;

    // Hue sectors of the color wheel
    localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
    localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
    localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
    localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
    localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [2:0] sector;
    } hue_ctl_t;

endpackage

// ===== src/golden_hue_hsv_to_rgb_core.sv =====
// Throughput: one id per cycle; busy stays low, four stages in flight at once.
// The output registers hold each result for one cycle only; the receiver cannot stall.
// Reset (rst_n low, asynchronous) clears the stage valid bits, drops done and
// sets saturation and brightness to 1.0.
// Stages: hue hash + chroma multiply, hue*6 split, c*f multiply, order + offset.
module golden_hue_hsv_to_rgb_core #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command side
    input  logic                           start,
    output logic                           busy,
    input  logic [ghue_pkg::ID_W-1:0]      object_id,
    // register write port
    input  logic                           write_enable,
    input  logic [ghue_pkg::IDX_W-1:0]     write_index,
    input  logic [ghue_pkg::CFG_W-1:0]     write_data,
    // result side
    output logic                           done,
    output logic [ghue_pkg::OUT_W-1:0]     red,
    output logic [ghue_pkg::OUT_W-1:0]     green,
    output logic [ghue_pkg::OUT_W-1:0]     blue
);

    // Working width of s, v, c, x, m: Q1.FRACTION_BITS
    localparam int QW = FRACTION_BITS + 1;
    localparam int EW = QW + ghue_pkg::CFG_W;
    localparam logic [EW-1:0] ONE_EXT = EW'(1) << FRACTION_BITS;

    logic [ghue_pkg::CFG_W-1:0] saturation_reg;
    logic [ghue_pkg::CFG_W-1:0] saturation_next;
    logic [ghue_pkg::CFG_W-1:0] brightness_reg;
    logic [ghue_pkg::CFG_W-1:0] brightness_next;

    logic [EW-1:0]      sat_ext;
    logic [EW-1:0]      bri_ext;
    logic [EW-1:0]      sat_cl;
    logic [EW-1:0]      bri_cl;

    ghue_pkg::hue_ctl_t hue_ctl;
    logic [31:0]        hue_frac;
    logic [QW-1:0]      hue_chroma;
    logic [QW-1:0]      hue_value;
    logic               accept;

    // The pipeline never stalls, so a new transaction is taken every cycle.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Register file: only two indexes exist, each write lands directly.
    always_comb
    begin
        saturation_next = saturation_reg;
        brightness_next = brightness_reg;
        if (write_enable)
        begin
            case (write_index)
                ghue_pkg::REG_SATURATION: saturation_next = write_data;
                ghue_pkg::REG_BRIGHTNESS: brightness_next = write_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_reg <= ghue_pkg::CFG_RESET;
            brightness_reg <= ghue_pkg::CFG_RESET;
        end
        else
        begin
            saturation_reg <= saturation_next;
            brightness_reg <= brightness_next;
        end
    end

    // Values above 1.0 saturate to 1.0 before use
    assign sat_ext = {{QW{1'b0}}, saturation_reg};
    assign bri_ext = {{QW{1'b0}}, brightness_reg};
    assign sat_cl  = (sat_ext > ONE_EXT) ? ONE_EXT : sat_ext;
    assign bri_cl  = (bri_ext > ONE_EXT) ? ONE_EXT : bri_ext;

    // Stages 1-2: hue, sector, fraction, chroma
    ghue_hue #(
        .QW(QW)
    ) u_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .object_id (object_id),
        .sat_q     (sat_cl[QW-1:0]),
        .val_q     (bri_cl[QW-1:0]),
        .ctl       (hue_ctl),
        .frac      (hue_frac),
        .chroma    (hue_chroma),
        .value     (hue_value)
    );

    // Stages 3-4: secondary component, sector ordering, offset
    ghue_mix #(
        .QW(QW)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (hue_ctl),
        .frac      (hue_frac),
        .chroma    (hue_chroma),
        .value     (hue_value),
        .out_valid (done),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

// ===== src/ghue_hue.sv =====
// Hue generation: golden-ratio hash of the id, then sector and fraction split; chroma.
module ghue_hue #(
    parameter int QW = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ghue_pkg::ID_W-1:0]   object_id,
    input  logic [QW-1:0]               sat_q,
    input  logic [QW-1:0]               val_q,
    output ghue_pkg::hue_ctl_t          ctl,
    output logic [31:0]                 frac,
    output logic [QW-1:0]               chroma,
    output logic [QW-1:0]               value
);

    localparam int FB = QW - 1;
    localparam logic [2*QW-1:0] HALF = (2*QW)'(1) << (FB - 1);

    logic                  valid1_reg;
    logic [31:0]           hue1_reg;
    logic [31:0]           hue1_next;
    logic [QW-1:0]         c1_reg;
    logic [QW-1:0]         c1_next;
    logic [QW-1:0]         v1_reg;
    logic [2*QW-1:0]       sv_prod;

    ghue_pkg::hue_ctl_t    ctl2_reg;
    ghue_pkg::hue_ctl_t    ctl2_next;
    logic [31:0]           f2_reg;
    logic [QW-1:0]         c2_reg;
    logic [QW-1:0]         v2_reg;
    logic [34:0]           h6;

    // Stage 1: hue = id * phi' + 0.13 (mod one turn); chroma = round(v * s)
    assign hue1_next = object_id * ghue_pkg::PHI_FRAC + ghue_pkg::OFFSET_FRAC;
    assign sv_prod   = (2*QW)'(val_q) * (2*QW)'(sat_q);
    always_comb
    begin
        logic [2*QW-1:0] rounded;
        rounded = sv_prod + HALF;
        c1_next = rounded[FB+QW-1:FB];
    end

    // Stage 2: hue * 6 = hue*4 + hue*2; sector in the top three bits
    assign h6 = ({3'b000, hue1_reg} << 2) + ({3'b000, hue1_reg} << 1);
    assign ctl2_next.valid  = valid1_reg;
    assign ctl2_next.sector = h6[34:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            ctl2_reg   <= '0;
        end
        else
        begin
            valid1_reg <= in_valid;
            ctl2_reg   <= ctl2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hue1_reg <= hue1_next;
        c1_reg   <= c1_next;
        v1_reg   <= val_q;
        f2_reg   <= h6[31:0];
        c2_reg   <= c1_reg;
        v2_reg   <= v1_reg;
    end

    assign ctl    = ctl2_reg;
    assign frac   = f2_reg;
    assign chroma = c2_reg;
    assign value  = v2_reg;

endmodule

// ===== src/ghue_mix.sv =====
// Secondary component x = c*f or c*(1-f), then sector ordering and offset add.
module ghue_mix #(
    parameter int QW = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ghue_pkg::hue_ctl_t           ctl,
    input  logic [31:0]                  frac,
    input  logic [QW-1:0]                chroma,
    input  logic [QW-1:0]                value,
    output logic                         out_valid,
    output logic [ghue_pkg::OUT_W-1:0]   red,
    output logic [ghue_pkg::OUT_W-1:0]   green,
    output logic [ghue_pkg::OUT_W-1:0]   blue
);

    localparam int PW = QW + 32;
    localparam logic [PW-1:0] ROUND32 = PW'(1) << 31;

    ghue_pkg::hue_ctl_t ctl3_reg;
    logic [PW-1:0]      p3_reg;
    logic [QW-1:0]      c3_reg;
    logic [QW-1:0]      v3_reg;

    logic               valid4_reg;
    logic [ghue_pkg::OUT_W-1:0] red_reg, green_reg, blue_reg;
    logic [ghue_pkg::OUT_W-1:0] red_next, green_next, blue_next;

    // Stage 3: c * f
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg   <= '0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            ctl3_reg   <= ctl;
            valid4_reg <= ctl3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p3_reg <= PW'(chroma) * PW'(frac);
        c3_reg <= chroma;
        v3_reg <= value;
    end

    // Stage 4: odd sectors use c*(1-f) = c<<32 - c*f
    always_comb
    begin
        logic [PW-1:0] xw;
        logic [QW-1:0] x;
        logic [QW-1:0] m;
        logic [QW-1:0] r, g, b;
        logic [QW+15:0] re, ge, be;
        if (ctl3_reg.sector[0])
            xw = ({c3_reg, 32'h0} - p3_reg) + ROUND32;
        else
            xw = p3_reg + ROUND32;
        x = xw[PW-1:32];
        m = v3_reg - c3_reg;
        case (ctl3_reg.sector)
            ghue_pkg::SEC_RED_YELLOW:
            begin
                r = c3_reg; g = x;      b = '0;
            end
            ghue_pkg::SEC_YELLOW_GREEN:
            begin
                r = x;      g = c3_reg; b = '0;
            end
            ghue_pkg::SEC_GREEN_CYAN:
            begin
                r = '0;     g = c3_reg; b = x;
            end
            ghue_pkg::SEC_CYAN_BLUE:
            begin
                r = '0;     g = x;      b = c3_reg;
            end
            ghue_pkg::SEC_BLUE_MAGENTA:
            begin
                r = x;      g = '0;     b = c3_reg;
            end
            default:
            begin
                r = c3_reg; g = '0;     b = x;
            end
        endcase
        // Components never exceed v; resize to the 16-bit port
        re = {16'h0, r + m};
        ge = {16'h0, g + m};
        be = {16'h0, b + m};
        red_next   = re[ghue_pkg::OUT_W-1:0];
        green_next = ge[ghue_pkg::OUT_W-1:0];
        blue_next  = be[ghue_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign out_valid = valid4_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ===== src/ghue_checker.sv =====
// Port-level checker for the hue color core, with its bind.
module ghue_checker #(
    parameter int FRACTION_BITS = 15
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [ghue_pkg::OUT_W-1:0]     red,
    input logic [ghue_pkg::OUT_W-1:0]     green,
    input logic [ghue_pkg::OUT_W-1:0]     blue
);

    localparam logic [31:0] ONE_Q = 32'(1) << FRACTION_BITS;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a pipeline that never stalls");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted transaction gave no result after 4 cycles");

    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without a transaction 4 cycles earlier");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(red) <= ONE_Q && 32'(green) <= ONE_Q && 32'(blue) <= ONE_Q))
        else $error("color component above 1.0");

endmodule

bind golden_hue_hsv_to_rgb_core ghue_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_ghue_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the golden-ratio hue HSV to RGB core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 15;

    // Q1.FB unity and rounding half for the chroma product
    localparam logic [63:0] UNITY = 64'd1 << FB;
    localparam logic [63:0] HALF_LSB = 64'd1 << (FB - 1);

    // Watchdog limit for the whole run; a correct run stays well under it.
    localparam int CYCLE_LIMIT = 500000;

    // Pipeline depth from the core header, plus margin.
    localparam int SETTLE_CYCLES = 8;

    localparam int RANDOM_PHASES = 8;
    localparam int IDS_PER_PHASE = 240;

    typedef struct {
        logic [ghue_pkg::ID_W-1:0]  id;
        logic [ghue_pkg::OUT_W-1:0] red;
        logic [ghue_pkg::OUT_W-1:0] green;
        logic [ghue_pkg::OUT_W-1:0] blue;
    } color_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [ghue_pkg::ID_W-1:0] object_id = '0;
    logic write_enable = 1'b0;
    logic [ghue_pkg::IDX_W-1:0] write_index = '0;
    logic [ghue_pkg::CFG_W-1:0] write_data = '0;
    logic busy;
    logic done;
    logic [ghue_pkg::OUT_W-1:0] red;
    logic [ghue_pkg::OUT_W-1:0] green;
    logic [ghue_pkg::OUT_W-1:0] blue;

    // Predictor's copy of the two config registers, reset to 1.0
    logic [ghue_pkg::CFG_W-1:0] cfg_saturation = ghue_pkg::CFG_RESET;
    logic [ghue_pkg::CFG_W-1:0] cfg_brightness = ghue_pkg::CFG_RESET;

    // Colors predicted for accepted ids, oldest first
    color_t pending_colors[$];

    int mismatch_count = 0;
    int cycle_count = 0;

    golden_hue_hsv_to_rgb_core #(
        .FRACTION_BITS(FB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .object_id(object_id),
        .write_enable(write_enable),
        .write_index(write_index),
        .write_data(write_data),
        .done(done),
        .red(red),
        .green(green),
        .blue(blue)
    );

    always #10 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Expected color for one id under the current register copy.
    function automatic color_t predict_color(logic [ghue_pkg::ID_W-1:0] id);
        logic [31:0] hue;
        logic [34:0] hue6;
        logic [2:0] sector;
        logic [63:0] frac;
        logic [63:0] sat;
        logic [63:0] val;
        logic [63:0] chroma;
        logic [63:0] second;
        logic [63:0] offset;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        color_t result;
        // hue wraps modulo one turn as a 0.32 fraction
        hue = id * ghue_pkg::PHI_FRAC + ghue_pkg::OFFSET_FRAC;
        hue6 = {3'b000, hue} * 35'd6;
        sector = hue6[34:32];
        frac = {32'd0, hue6[31:0]};
        // registers above one saturate to one
        sat = ({48'd0, cfg_saturation} > UNITY) ? UNITY : {48'd0, cfg_saturation};
        val = ({48'd0, cfg_brightness} > UNITY) ? UNITY : {48'd0, cfg_brightness};
        chroma = (val * sat + HALF_LSB) >> FB;
        if (chroma > val)
        begin
            chroma = val;
        end
        // odd sectors ramp down, even sectors ramp up
        if (sector[0])
        begin
            second = (chroma * ((64'd1 << 32) - frac) + (64'd1 << 31)) >> 32;
        end
        else
        begin
            second = (chroma * frac + (64'd1 << 31)) >> 32;
        end
        offset = val - chroma;
        case (sector)
            ghue_pkg::SEC_RED_YELLOW:
            begin
                r = chroma; g = second; b = 0;
            end
            ghue_pkg::SEC_YELLOW_GREEN:
            begin
                r = second; g = chroma; b = 0;
            end
            ghue_pkg::SEC_GREEN_CYAN:
            begin
                r = 0; g = chroma; b = second;
            end
            ghue_pkg::SEC_CYAN_BLUE:
            begin
                r = 0; g = second; b = chroma;
            end
            ghue_pkg::SEC_BLUE_MAGENTA:
            begin
                r = second; g = 0; b = chroma;
            end
            default:
            begin
                // magenta to red
                r = chroma; g = 0; b = second;
            end
        endcase
        r = r + offset;
        g = g + offset;
        b = b + offset;
        result.id = id;
        result.red = r[ghue_pkg::OUT_W-1:0];
        result.green = g[ghue_pkg::OUT_W-1:0];
        result.blue = b[ghue_pkg::OUT_W-1:0];
        return result;
    endfunction

    task automatic report_mismatch(string what, logic [ghue_pkg::ID_W-1:0] id,
                                   logic [ghue_pkg::OUT_W-1:0] want,
                                   logic [ghue_pkg::OUT_W-1:0] got);
        $display("MISMATCH %s id=%08h expected=%0d got=%0d at cycle %0d",
                 what, id, want, got, cycle_count);
        mismatch_count++;
    endtask

    // Result monitor: done and the color are sampled at the edge that ends
    // the strobe cycle, before the core's registers move.
    always @(posedge clk)
    begin
        color_t want;
        if (rst_n && done)
        begin
            if (pending_colors.size() == 0)
            begin
                report_mismatch("unexpected result, red", '0, '0, red);
            end
            else
            begin
                want = pending_colors.pop_front();
                if (red !== want.red)
                begin
                    report_mismatch("red", want.id, want.red, red);
                end
                if (green !== want.green)
                begin
                    report_mismatch("green", want.id, want.green, green);
                end
                if (blue !== want.blue)
                begin
                    report_mismatch("blue", want.id, want.blue, blue);
                end
            end
        end
    end

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            return $urandom_range(4, 9);
        end
        return $urandom_range(10, 40);
    endfunction

    // Register values: the extremes, above one, and the legal range.
    function automatic logic [ghue_pkg::CFG_W-1:0] pick_cfg();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            return '0;
        end
        else if (roll < 20)
        begin
            return ghue_pkg::CFG_RESET;
        end
        else if (roll < 30)
        begin
            return (ghue_pkg::CFG_W)'($urandom_range(32769, 65535));
        end
        return (ghue_pkg::CFG_W)'($urandom_range(0, 32768));
    endfunction

    function automatic logic [ghue_pkg::ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            return (ghue_pkg::ID_W)'($urandom_range(0, 255));
        end
        else if (roll < 20)
        begin
            return ~(ghue_pkg::ID_W)'($urandom_range(0, 255));
        end
        return $urandom;
    endfunction

    // One command transaction: start held until an edge with busy low.
    // Start is left high when the next id follows with no gap.
    task automatic send_id(logic [ghue_pkg::ID_W-1:0] id, int gap);
        @(negedge clk);
        start <= 1'b1;
        object_id <= id;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_colors.push_back(predict_color(id));
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait out every predicted color plus the pipeline.
    task automatic drain_colors();
        @(negedge clk);
        start <= 1'b0;
        while (pending_colors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write; only called with the core drained.
    task automatic write_reg(logic [ghue_pkg::IDX_W-1:0] idx,
                             logic [ghue_pkg::CFG_W-1:0] data);
        @(negedge clk);
        write_enable <= 1'b1;
        write_index <= idx;
        write_data <= data;
        @(negedge clk);
        write_enable <= 1'b0;
        if (idx == ghue_pkg::REG_SATURATION)
        begin
            cfg_saturation = data;
        end
        else if (idx == ghue_pkg::REG_BRIGHTNESS)
        begin
            cfg_brightness = data;
        end
    endtask

    task automatic set_hsv(logic [ghue_pkg::CFG_W-1:0] sat,
                           logic [ghue_pkg::CFG_W-1:0] val);
        drain_colors();
        write_reg(ghue_pkg::REG_SATURATION, sat);
        write_reg(ghue_pkg::REG_BRIGHTNESS, val);
    endtask

    // Reset values are 1.0; ids 0..5 land in all six hue sectors.
    task automatic test_reset_values();
        for (int i = 0; i < 6; i++)
        begin
            send_id((ghue_pkg::ID_W)'(i), i % 2);
        end
    endtask

    // Wraparound of the hue hash on large ids and alternating bit patterns.
    task automatic test_id_extremes();
        send_id(32'hFFFF_FFFF, 0);
        send_id(32'h8000_0000, 1);
        send_id(32'h7FFF_FFFF, 0);
        send_id(32'hAAAA_AAAA, 2);
        send_id(32'h5555_5555, 0);
    endtask

    // Zero saturation (gray), zero value (black), both zero, all-ones data
    // that saturates to one, and just above one.
    task automatic test_register_extremes();
        set_hsv(16'h0000, ghue_pkg::CFG_RESET);
        send_id(32'd1, 0);
        send_id(32'd3, 0);
        set_hsv(ghue_pkg::CFG_RESET, 16'h0000);
        send_id(32'd2, 0);
        send_id(32'd4, 0);
        set_hsv(16'h0000, 16'h0000);
        send_id(32'hFFFF_FFFF, 0);
        set_hsv(16'hFFFF, 16'hFFFF);
        send_id(32'd0, 0);
        send_id(32'd5, 0);
        set_hsv(16'h8001, 16'h4000);
        send_id(32'd1, 0);
        send_id(32'hDEAD_BEEF, 0);
    endtask

    // Sender pauses mid-stream until every outstanding color is back.
    task automatic test_drain_pause();
        set_hsv(16'h6000, 16'h7000);
        repeat (20) send_id(pick_id(), 0);
        drain_colors();
        repeat (20) send_id(pick_id(), pick_gap());
    endtask

    // Random ids over several register settings; some phases run with no
    // idling at all, others with random gaps and the odd full drain.
    task automatic test_random_colors();
        bit burst;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_hsv(ghue_pkg::CFG_RESET, ghue_pkg::CFG_RESET);
                1: set_hsv(16'hFFFF, 16'h0000);
                2: set_hsv(16'h0000, 16'hFFFF);
                default: set_hsv(pick_cfg(), pick_cfg());
            endcase
            burst = (phase == 3) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < IDS_PER_PHASE; n++)
            begin
                if (!burst && $urandom_range(0, 79) == 0)
                begin
                    drain_colors();
                end
                send_id(pick_id(), burst ? 0 : pick_gap());
            end
        end
    endtask

    initial
    begin
        // Reset held low from time zero, released on a falling edge
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_id_extremes();
        test_register_extremes();
        test_drain_pause();
        test_random_colors();

        drain_colors();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
